// ----- rtl/assert_macros.svh -----
// Assertion macros for the particle step RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, off while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pgsw_pkg.sv -----
// Types, constants and helpers for the particle step block.
package pgsw_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int NUM_CFG = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BORDER_X  = 3'd0,
    CFG_BORDER_Y  = 3'd1,
    CFG_GRAVITY_X = 3'd2,
    CFG_GRAVITY_Y = 3'd3,
    CFG_TIME_STEP = 3'd4
  } cfg_idx_t;

  localparam logic [15:0] TIME_STEP_RST = 16'd328;
  localparam longint BORDER_X_WHOLE = 1280;
  localparam longint BORDER_Y_WHOLE = 960;
  localparam longint MAX31 = 64'h7fff_ffff;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        radius;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               bounced_x;
    logic               bounced_y;
  } out_item_t;

  // Data carried along the speed and divide pipelines.
  typedef struct packed {
    logic signed [32:0] pxw;
    logic signed [32:0] pyw;
    logic signed [32:0] vxw;
    logic signed [32:0] vyw;
    logic               hx;
    logic               hy;
    logic [63:0]        num_mag;
    logic               num_neg;
  } pay_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    if (x > 36'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (x < -36'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  function automatic logic [31:0] abs33(input logic signed [32:0] x);
    logic signed [32:0] n;
    n = -x;
    return x[32] ? n[31:0] : x[31:0];
  endfunction

endpackage

// ----- rtl/particle_gravity_step_with_walls.sv -----
// Particle step under constant gravity with wall reflection, fully pipelined.
//
//  channel | signals                           | meaning
//  in      | in_valid, in_ready, in_data       | one particle per transfer
//  out     | out_valid, out_ready, out_data    | updated particle per transfer
//  cfg     | cfg_we, cfg_index, cfg_data       | register write, no wait
//
// One item enters per cycle while the output is not stalled; the 32-step square
// root and the 33-step divider form the bounce correction.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Synchronous reset clears the valid bits and restores register defaults.
module particle_gravity_step_with_walls
  import pgsw_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam longint BX_FULL = BORDER_X_WHOLE << FRAC_BITS;
  localparam longint BY_FULL = BORDER_Y_WHOLE << FRAC_BITS;
  localparam logic [30:0] BX_RST = (BX_FULL > MAX31) ? 31'h7fff_ffff : BX_FULL[30:0];
  localparam logic [30:0] BY_RST = (BY_FULL > MAX31) ? 31'h7fff_ffff : BY_FULL[30:0];
  localparam logic [31:0] TT_RST = 32'(TIME_STEP_RST) * 32'(TIME_STEP_RST);

  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = 33;
  localparam int NST = 5 + SQ_STEPS + 1 + DV_STEPS + 1;

  // configuration
  logic [30:0]        border_x, border_y;
  logic signed [31:0] gravity_x, gravity_y;
  logic [15:0]        time_step;
  logic [31:0]        tt;

  // dt^2 is written together with dt, so the next transfer sees both
  always_ff @(posedge clk) begin
    if (rst) begin
      border_x  <= BX_RST;
      border_y  <= BY_RST;
      gravity_x <= '0;
      gravity_y <= '0;
      time_step <= TIME_STEP_RST;
      tt        <= TT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BORDER_X:  border_x  <= cfg_data[30:0];
        CFG_BORDER_Y:  border_y  <= cfg_data[30:0];
        CFG_GRAVITY_X: gravity_x <= cfg_data;
        CFG_GRAVITY_Y: gravity_y <= cfg_data;
        CFG_TIME_STEP: begin
          time_step <= cfg_data[15:0];
          tt        <= cfg_data[15:0] * cfg_data[15:0];
        end
        default: ;
      endcase
    end
  end

  logic [NST-1:0] vld;
  logic           en;

  assign en       = !vld[NST-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // stage 1: products of the free step
  logic signed [31:0] s1_px, s1_py, s1_vx, s1_vy;
  logic [30:0]        s1_r;
  logic signed [48:0] s1_mvx, s1_mvy, s1_mgx, s1_mgy;
  logic signed [64:0] s1_mgx2, s1_mgy2;
  logic signed [16:0] t17;

  assign t17 = $signed({1'b0, time_step});

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px   <= in_data.pos_x;
      s1_py   <= in_data.pos_y;
      s1_vx   <= in_data.vel_x;
      s1_vy   <= in_data.vel_y;
      s1_r    <= in_data.radius;
      s1_mvx  <= in_data.vel_x * t17;
      s1_mvy  <= in_data.vel_y * t17;
      s1_mgx  <= gravity_x * t17;
      s1_mgy  <= gravity_y * t17;
      s1_mgx2 <= gravity_x * $signed({1'b0, tt});
      s1_mgy2 <= gravity_y * $signed({1'b0, tt});
    end
  end

  // stage 2: sums with floor shifts, saturated
  logic signed [31:0] s2_px, s2_py, s2_vx, s2_vy;
  logic [30:0]        s2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_px <= sat32(36'(s1_px) + 36'($signed(s1_mvx[48:16])) + 36'($signed(s1_mgx2[64:33])));
      s2_py <= sat32(36'(s1_py) + 36'($signed(s1_mvy[48:16])) + 36'($signed(s1_mgy2[64:33])));
      s2_vx <= sat32(36'(s1_vx) + 36'($signed(s1_mgx[48:16])));
      s2_vy <= sat32(36'(s1_vy) + 36'($signed(s1_mgy[48:16])));
      s2_r  <= s1_r;
    end
  end

  // stage 3: walls
  logic signed [35:0] rr, bx, by, px36, py36;
  logic               lt_x, gt_x, lt_y, gt_y;
  logic signed [35:0] pxw_c, pyw_c, dep_c;
  pay_t               s3_pay;
  logic [31:0]        s3_dep;
  logic signed [31:0] s3_gy;

  assign rr   = 36'($signed({1'b0, s2_r}));
  assign bx   = 36'($signed({1'b0, border_x}));
  assign by   = 36'($signed({1'b0, border_y}));
  assign px36 = 36'(s2_px);
  assign py36 = 36'(s2_py);
  assign lt_x = (px36 - rr) < 0;
  assign gt_x = (px36 + rr) > bx;
  assign lt_y = (py36 - rr) < 0;
  assign gt_y = (py36 + rr) > by;

  always_comb begin
    pxw_c = lt_x ? rr : (gt_x ? bx - rr : px36);
    pyw_c = lt_y ? rr : (gt_y ? by - rr : py36);
    dep_c = lt_y ? rr - py36 : py36 + rr - by;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pay.pxw     <= pxw_c[32:0];
      s3_pay.pyw     <= pyw_c[32:0];
      s3_pay.vxw     <= (lt_x || gt_x) ? -33'(s2_vx) : 33'(s2_vx);
      s3_pay.vyw     <= (lt_y || gt_y) ? -33'(s2_vy) : 33'(s2_vy);
      s3_pay.hx      <= lt_x || gt_x;
      s3_pay.hy      <= lt_y || gt_y;
      s3_pay.num_mag <= '0;
      s3_pay.num_neg <= gravity_y[31];
      s3_dep         <= dep_c[31:0];
      s3_gy          <= gravity_y;
    end
  end

  // stage 4: squares and correction numerator
  pay_t        s4_pay, s4_pay_c;
  logic [63:0] s4_sqx, s4_sqy;
  logic [31:0] ax, ay, agy;

  assign ax  = abs33(s3_pay.vxw);
  assign ay  = abs33(s3_pay.vyw);
  assign agy = abs33(33'(s3_gy));

  always_comb begin
    s4_pay_c         = s3_pay;
    s4_pay_c.num_mag = agy * s3_dep;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_pay <= s4_pay_c;
      s4_sqx <= ax * ax;
      s4_sqy <= ay * ay;
    end
  end

  // stage 5 and square root pipeline
  pay_t        sq_pay  [SQ_STEPS+1];
  logic [63:0] sq_n    [SQ_STEPS+1];
  logic [33:0] sq_rem  [SQ_STEPS+1];
  logic [31:0] sq_root [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_pay[0]  <= s4_pay;
      sq_n[0]    <= s4_sqx + s4_sqy;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    logic [35:0] sh, trial, diff;
    logic        ge;
    always_comb begin
      sh    = {sq_rem[k], sq_n[k][63:62]};
      trial = {2'b00, sq_root[k], 2'b01};
      ge    = sh >= trial;
      diff  = sh - trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_pay[k+1]  <= sq_pay[k];
        sq_n[k+1]    <= {sq_n[k][61:0], 2'b00};
        sq_rem[k+1]  <= ge ? diff[33:0] : sh[33:0];
        sq_root[k+1] <= {sq_root[k][30:0], ge};
      end
    end
  end

  // divider: |num| / speed, quotient kept to 33 bits plus an overflow flag
  pay_t        dv_pay  [DV_STEPS+1];
  logic [31:0] dv_rem  [DV_STEPS+1];
  logic [32:0] dv_q    [DV_STEPS+1];
  logic [32:0] dv_num  [DV_STEPS+1];
  logic [31:0] dv_spd  [DV_STEPS+1];
  logic        dv_ovf  [DV_STEPS+1];
  logic        d0_ovf;

  assign d0_ovf = {1'b0, sq_pay[SQ_STEPS].num_mag[63:33]} >= sq_root[SQ_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_pay[0] <= sq_pay[SQ_STEPS];
      dv_rem[0] <= d0_ovf ? 32'd0 : {1'b0, sq_pay[SQ_STEPS].num_mag[63:33]};
      dv_q[0]   <= '0;
      dv_num[0] <= sq_pay[SQ_STEPS].num_mag[32:0];
      dv_spd[0] <= sq_root[SQ_STEPS];
      dv_ovf[0] <= d0_ovf;
    end
  end

  for (genvar j = 0; j < DV_STEPS; j++) begin : g_dv
    logic [32:0] sh, diff;
    logic        ge;
    always_comb begin
      sh   = {dv_rem[j], dv_num[j][32]};
      ge   = sh >= {1'b0, dv_spd[j]};
      diff = sh - {1'b0, dv_spd[j]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_pay[j+1] <= dv_pay[j];
        dv_rem[j+1] <= ge ? diff[31:0] : sh[31:0];
        dv_q[j+1]   <= {dv_q[j][31:0], ge};
        dv_num[j+1] <= {dv_num[j][31:0], 1'b0};
        dv_spd[j+1] <= dv_spd[j];
        dv_ovf[j+1] <= dv_ovf[j];
      end
    end
  end

  // final stage: apply correction, saturate, output register
  pay_t               fp;
  logic [32:0]        qc;
  logic signed [35:0] corr;
  logic               apply;

  assign fp    = dv_pay[DV_STEPS];
  assign qc    = (dv_ovf[DV_STEPS] || dv_q[DV_STEPS] > 33'h1_0000_0000) ?
                 33'h1_0000_0000 : dv_q[DV_STEPS];
  assign apply = fp.hy && (dv_spd[DV_STEPS] != '0);
  assign corr  = !apply ? 36'sd0 :
                 (fp.num_neg ? -$signed({3'b000, qc}) : $signed({3'b000, qc}));

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.new_pos_x <= sat32(36'(fp.pxw));
      out_data.new_pos_y <= sat32(36'(fp.pyw));
      out_data.new_vel_x <= sat32(36'(fp.vxw));
      out_data.new_vel_y <= sat32(36'(fp.vyw) + corr);
      out_data.bounced_x <= fp.hx;
      out_data.bounced_y <= fp.hy;
    end
  end

  assign out_valid = vld[NST-1];

  `include "assert_macros.svh"

  `ASSERT_CLK(a_stall_freezes, !en |=> $stable(vld), "pipeline moved during stall")
  `ASSERT_CLK_ALL(a_reset_empties, rst |=> (vld == '0), "pipeline not empty after reset")
  `ASSERT_CLK(a_accept_enters, (in_valid && in_ready) |=> vld[0], "accepted item lost")

endmodule

// ----- bench/tb_particle_gravity_step_with_walls.sv -----
// Self-checking testbench for the particle gravity step block with wall bounces.
`timescale 1ns / 1ps

module tb_particle_gravity_step_with_walls;
  import pgsw_pkg::*;

  localparam int              CYCLE_LIMIT = 400000;
  localparam int              DRAIN_WAIT  = 80;
  localparam int              PHASE_ITEMS = 200;
  localparam int              NUM_PHASES  = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct {
    in_item_t  p;
    bit        known;
    out_item_t res;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  // register mirror
  longint          wall_x, wall_y, grav_x, grav_y, dt_frac;
  out_item_t       pending_results[$];
  int              mismatches;
  int              cycles;
  int              tx_idle_pct;
  int              rx_idle_pct;
  dir_row_t        dir_rows[$];

  particle_gravity_step_with_walls i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic out_item_t step_particle(in_item_t p);
    longint          px, py, vx, vy, rad, tt, depth, num;
    longint unsigned ax, ay, spd, q;
    bit              hx, hy;
    out_item_t       o;
    px  = p.pos_x;
    py  = p.pos_y;
    vx  = p.vel_x;
    vy  = p.vel_y;
    rad = p.radius;
    tt  = dt_frac * dt_frac;
    hx  = 0;
    hy  = 0;
    px = clamp32(px + ((vx * dt_frac) >>> 16) + ((grav_x * tt) >>> 33));
    py = clamp32(py + ((vy * dt_frac) >>> 16) + ((grav_y * tt) >>> 33));
    vx = clamp32(vx + ((grav_x * dt_frac) >>> 16));
    vy = clamp32(vy + ((grav_y * dt_frac) >>> 16));
    if (px - rad < 0) begin
      hx = 1; vx = -vx; px = rad;
    end else if (px + rad > wall_x) begin
      hx = 1; vx = -vx; px = wall_x - rad;
    end
    if (py - rad < 0 || py + rad > wall_y) begin
      hy = 1;
      vy = -vy;
      if (py - rad < 0) begin
        depth = rad - py; py = rad;
      end else begin
        depth = py - wall_y + rad; py = wall_y - rad;
      end
      ax  = (vx < 0) ? -vx : vx;
      ay  = (vy < 0) ? -vy : vy;
      spd = root_floor(ax * ax + ay * ay);
      // correction skipped at zero speed
      if (spd != 0) begin
        num = grav_y * depth;
        q   = ((num < 0) ? -num : num) / spd;
        if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
        vy += (num < 0) ? -longint'(q) : longint'(q);
      end
    end
    o.new_pos_x = 32'(clamp32(px));
    o.new_pos_y = 32'(clamp32(py));
    o.new_vel_x = 32'(clamp32(vx));
    o.new_vel_y = 32'(clamp32(vy));
    o.bounced_x = hx;
    o.bounced_y = hy;
    return o;
  endfunction

  function automatic logic [31:0] srand(int unsigned mag);
    logic [31:0] v;
    v = $urandom_range(0, mag);
    return ($urandom_range(0, 1) != 0) ? -v : v;
  endfunction

  function automatic in_item_t rand_particle();
    in_item_t p;
    int       kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      // inside the box, modest speed
      p.pos_x  = $urandom_range(0, int'(wall_x));
      p.pos_y  = $urandom_range(0, int'(wall_y));
      p.vel_x  = srand(32'h0100_0000);
      p.vel_y  = srand(32'h0100_0000);
      p.radius = 31'($urandom_range(0, 32'h0040_0000));
    end else if (kind < 85) begin
      // close to a wall
      p.pos_x  = 32'((($urandom_range(0, 1) != 0) ? wall_x : 0) + srand(32'h0010_0000));
      p.pos_y  = 32'((($urandom_range(0, 1) != 0) ? wall_y : 0) + srand(32'h0010_0000));
      p.vel_x  = srand(32'h0400_0000);
      p.vel_y  = srand(32'h0400_0000);
      p.radius = 31'($urandom_range(0, 32'h0010_0000));
    end else begin
      p.pos_x  = $urandom;
      p.pos_y  = $urandom;
      p.vel_x  = $urandom;
      p.vel_y  = $urandom;
      p.radius = 31'($urandom);
    end
    return p;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_BORDER_X:  wall_x  = longint'(val[30:0]);
      CFG_BORDER_Y:  wall_y  = longint'(val[30:0]);
      CFG_GRAVITY_X: grav_x  = longint'(signed'(val));
      CFG_GRAVITY_Y: grav_y  = longint'(signed'(val));
      CFG_TIME_STEP: dt_frac = longint'(val[15:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] bx, input logic [31:0] by,
                          input logic [31:0] gx, input logic [31:0] gy,
                          input logic [31:0] ts);
    wait_idle();
    write_reg(CFG_BORDER_X, bx);
    write_reg(CFG_BORDER_Y, by);
    write_reg(CFG_GRAVITY_X, gx);
    write_reg(CFG_GRAVITY_Y, gy);
    write_reg(CFG_TIME_STEP, ts);
    cfg_we <= 1'b0;
  endtask

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_particle(input in_item_t p, input bit known, input out_item_t res);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), known ? res : step_particle(p));
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t exp;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp = pending_results.pop_front();
    if (got.new_pos_x !== exp.new_pos_x || got.new_pos_y !== exp.new_pos_y ||
        got.new_vel_x !== exp.new_vel_x || got.new_vel_y !== exp.new_vel_y ||
        got.bounced_x !== exp.bounced_x || got.bounced_y !== exp.bounced_y) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch exp pos %h %h vel %h %h b %b%b", exp.new_pos_x, exp.new_pos_y,
                 exp.new_vel_x, exp.new_vel_y, exp.bounced_x, exp.bounced_y);
        $display("         got pos %h %h vel %h %h b %b%b", got.new_pos_x, got.new_pos_y,
                 got.new_vel_x, got.new_vel_y, got.bounced_x, got.bounced_y);
      end
    end
  endtask

  task automatic add_row(input logic [31:0] px, input logic [31:0] py, input logic [31:0] vx,
                         input logic [31:0] vy, input logic [31:0] r, input bit known,
                         input logic [31:0] ex, input logic [31:0] ey, input logic [1:0] eb);
    dir_row_t row;
    row.p.pos_x = px;
    row.p.pos_y = py;
    row.p.vel_x = vx;
    row.p.vel_y = vy;
    row.p.radius = r[30:0];
    row.known = known;
    row.res.new_pos_x = ex;
    row.res.new_pos_y = ey;
    row.res.new_vel_x = '0;
    row.res.new_vel_y = '0;
    {row.res.bounced_x, row.res.bounced_y} = eb;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      if (out_valid && out_ready) check_result(out_data);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("particle_gravity_step_with_walls regression: fail");
      $finish;
    end
  end

  initial begin
    in_item_t  p;
    out_item_t none;
    mismatches  = 0;
    cycles      = 0;
    tx_idle_pct = 9;
    rx_idle_pct = 79;
    none        = '0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    wall_x  = 1280 << 16;
    wall_y  = 960 << 16;
    grav_x  = 0;
    grav_y  = 0;
    dt_frac = 328;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // resting particles with gravity off keep their place; wall hits clamp
    add_row(100 << 16, 100 << 16, 0, 0, 1 << 16, 1, 100 << 16, 100 << 16, 2'b00);
    add_row(0, 100 << 16, 0, 0, 5 << 16, 1, 5 << 16, 100 << 16, 2'b10);
    add_row(100 << 16, 0, 0, 0, 5 << 16, 1, 100 << 16, 5 << 16, 2'b01);
    add_row(1280 << 16, 100 << 16, 0, 0, 1 << 16, 1, 1279 << 16, 100 << 16, 2'b10);
    add_row(100 << 16, 960 << 16, 0, 0, 1 << 16, 1, 100 << 16, 959 << 16, 2'b01);
    // corner hit, moving into it
    add_row(0, 0, -(1 << 16), -(1 << 16), 2 << 16, 0, 0, 0, 2'b00);
    // radius larger than the box: both walls at once
    add_row(10 << 16, 10 << 16, 3 << 16, -(3 << 16), 32'h7fff_ffff, 0, 0, 0, 2'b00);
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0, 2'b00);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 2'b00);
    add_row(640 << 16, 480 << 16, 32'h7fff_ffff, 32'h8000_0000, 1, 0, 0, 0, 2'b00);
    add_row(640 << 16, 480 << 16, 32'h8000_0000, 32'h7fff_ffff, 1, 0, 0, 0, 2'b00);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 2'b00);
    // zero speed on the floor: correction skipped
    add_row(300 << 16, 0, 0, 0, 1 << 16, 0, 0, 0, 2'b00);
    add_row(300 << 16, 955 << 16, 0, 500 << 16, 8 << 16, 0, 0, 0, 2'b00);

    foreach (dir_rows[i]) send_particle(dir_rows[i].p, dir_rows[i].known, dir_rows[i].res);
    in_valid <= 1'b0;
    set_regs(1280 << 16, 960 << 16, -(32'h0001_8000), 32'h0009_cccc, 32'h0000_ffff);
    foreach (dir_rows[i]) send_particle(dir_rows[i].p, 0, none);
    in_valid <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        set_regs(0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_ffff);
      end else if (ph == 1) begin
        set_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
      end else if (($urandom_range(0, 1)) != 0) begin
        set_regs($urandom_range(1 << 16, 2000 << 16), $urandom_range(1 << 16, 2000 << 16),
                 srand(32'h0020_0000), srand(32'h0020_0000), $urandom_range(0, 32'h0000_ffff));
      end else begin
        set_regs($urandom, $urandom, $urandom, $urandom, $urandom);
      end
      if (ph == 2) begin
        // writes to an unused index leave every register alone
        write_reg(CFG_UNUSED, $urandom);
        cfg_we <= 1'b0;
      end
      tx_idle_pct = (ph < 3) ? 9 : (ph < 5) ? 79 : 0;
      rx_idle_pct = (ph < 3) ? 79 : (ph < 5) ? 9 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        p = rand_particle();
        send_particle(p, 0, none);
      end
      in_valid <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("particle_gravity_step_with_walls regression: pass");
    end else begin
      $display("particle_gravity_step_with_walls regression: fail");
    end
    $finish;
  end

endmodule

// ----- particle_gravity_step_with_walls.f -----
+incdir+rtl
rtl/pgsw_pkg.sv
rtl/particle_gravity_step_with_walls.sv
bench/tb_particle_gravity_step_with_walls.sv
